// ----- rtl/rc4_pkg.sv -----
// Shared constants, sequencer states and memory request types for the RC4 block.
`default_nettype none
package rc4_pkg;

	localparam int SBOX_DEPTH    = 256;
	localparam int ADDR_W        = $clog2(SBOX_DEPTH);
	localparam int MAX_KEY_BYTES = 256;
	localparam int CNT_W         = $clog2(MAX_KEY_BYTES + 1);
	localparam int KEY_ADDR_W    = $clog2(MAX_KEY_BYTES);

	localparam logic CMD_KEY  = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	typedef logic [ADDR_W-1:0] byte_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_K_RD,
		ST_K_ADD,
		ST_K_WR_N,
		ST_K_WR_J,
		ST_P_RDI,
		ST_P_RDJ,
		ST_P_WR_I,
		ST_P_WR_J,
		ST_P_RDK,
		ST_P_OUT
	} state_t;

	typedef struct packed {
		logic  clr;
		logic  we;
		byte_t wr_addr;
		byte_t wr_data;
		byte_t rd_addr;
	} sbox_req_t;

	typedef struct packed {
		logic                  we;
		logic [KEY_ADDR_W-1:0] wr_addr;
		byte_t                 wr_data;
		logic [KEY_ADDR_W-1:0] rd_addr;
	} key_req_t;

endpackage
`default_nettype wire

// ----- rtl/rc4_in_if.sv -----
// Input request channel: command, byte value and key-last flag.
`default_nettype none
interface rc4_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] value;
	logic       key_last;

	modport source (output valid, output cmd, output value, output key_last, input ready);
	modport sink (input valid, input cmd, input value, input key_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/rc4_out_if.sv -----
// Output request channel: one ciphered byte.
`default_nettype none
interface rc4_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;

	modport source (output valid, output out_byte, input ready);
	modport sink (input valid, input out_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/rc4_stream_cipher.sv -----
// RC4 keystream cipher: key byte loading, key schedule and per-byte keystream XOR.
// Key byte without key_last: taken while idle; the block stays ready.
// Key byte with key_last: busy for 256 swap steps, each through K_RD, K_ADD, K_WR_N, K_WR_J.
// Data byte: passes P_RDI, P_RDJ, P_WR_I, P_WR_J, P_RDK, P_OUT, then loads the output register
// once free; no new byte is taken until then, set by the dependent S-box reads and two writes.
// Reset: asynchronous; S-box valid bits clear to identity at once, indices and key count zero.
`default_nettype none
module rc4_stream_cipher (
	input  wire logic clk,
	input  wire logic arst_n,
	rc4_in_if.sink    din,
	rc4_out_if.source dout
);

	rc4_pkg::sbox_req_t sbox_req;
	rc4_pkg::key_req_t  key_req;
	rc4_pkg::byte_t     sbox_rdata;
	rc4_pkg::byte_t     key_rdata;

	rc4_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (din),
		.dout       (dout),
		.sbox_req   (sbox_req),
		.sbox_rdata (sbox_rdata),
		.key_req    (key_req),
		.key_rdata  (key_rdata)
	);

	rc4_sbox_mem u_sbox (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sbox_req),
		.rdata  (sbox_rdata)
	);

	rc4_key_mem u_key (
		.clk   (clk),
		.req   (key_req),
		.rdata (key_rdata)
	);

endmodule
`default_nettype wire

// ----- rtl/rc4_sbox_mem.sv -----
// S-box memory with per-entry valid bits; an unwritten entry reads as its own index.
`default_nettype none
module rc4_sbox_mem (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rc4_pkg::sbox_req_t req,
	output logic [rc4_pkg::ADDR_W-1:0] rdata
);

	logic [rc4_pkg::ADDR_W-1:0] mem [rc4_pkg::SBOX_DEPTH];
	logic [rc4_pkg::SBOX_DEPTH-1:0] vld_q;
	logic [rc4_pkg::ADDR_W-1:0] data_q;
	logic [rc4_pkg::ADDR_W-1:0] addr_q;
	logic vld_rd_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		data_q <= mem[req.rd_addr];
		addr_q <= req.rd_addr;
	end

	// drop all entries back to identity on clear, mark written entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (req.clr) begin
				vld_q <= '0;
			end else if (req.we) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			vld_rd_q <= vld_q[req.rd_addr];
		end
	end

	assign rdata = vld_rd_q ? data_q : addr_q;

endmodule
`default_nettype wire

// ----- rtl/rc4_key_mem.sv -----
// Key byte store with one write port and a registered read port.
`default_nettype none
module rc4_key_mem (
	input  wire logic              clk,
	input  wire rc4_pkg::key_req_t req,
	output logic [rc4_pkg::ADDR_W-1:0] rdata
);

	logic [rc4_pkg::ADDR_W-1:0] mem [rc4_pkg::MAX_KEY_BYTES];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		rdata <= mem[req.rd_addr];
	end

endmodule
`default_nettype wire

// ----- rtl/rc4_seq.sv -----
// Sequencer with one shared byte adder: key loading, key schedule and keystream steps.
`default_nettype none
module rc4_seq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	rc4_in_if.sink                  din,
	rc4_out_if.source               dout,
	output rc4_pkg::sbox_req_t      sbox_req,
	input  wire rc4_pkg::byte_t     sbox_rdata,
	output rc4_pkg::key_req_t       key_req,
	input  wire rc4_pkg::byte_t     key_rdata
);

	rc4_pkg::state_t state_q, state_d;

	rc4_pkg::byte_t i_q, j_q, n_q, kidx_q, si_q, sj_q, val_q, out_q;
	logic [rc4_pkg::CNT_W-1:0] key_count_q, len_q;
	logic out_valid_q;

	rc4_pkg::byte_t add_a, add_b, add_c, add_sum;
	logic accept, store_ok, out_free;
	logic [rc4_pkg::CNT_W-1:0] count_inc, kidx_inc;

	assign accept    = din.valid && din.ready;
	assign store_ok  = key_count_q < rc4_pkg::CNT_W'(rc4_pkg::MAX_KEY_BYTES);
	assign count_inc = key_count_q + rc4_pkg::CNT_W'(1);
	assign kidx_inc  = rc4_pkg::CNT_W'(kidx_q) + rc4_pkg::CNT_W'(1);
	assign out_free  = !out_valid_q || dout.ready;

	// shared adder
	assign add_sum = add_a + add_b + add_c;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rc4_pkg::ST_IDLE: begin
				if (accept) begin
					if (din.cmd == rc4_pkg::CMD_DATA) begin
						state_d = rc4_pkg::ST_P_RDI;
					end else if (din.key_last) begin
						state_d = rc4_pkg::ST_K_RD;
					end
				end
			end
			rc4_pkg::ST_K_RD:   state_d = rc4_pkg::ST_K_ADD;
			rc4_pkg::ST_K_ADD:  state_d = rc4_pkg::ST_K_WR_N;
			rc4_pkg::ST_K_WR_N: state_d = rc4_pkg::ST_K_WR_J;
			rc4_pkg::ST_K_WR_J: begin
				state_d = (n_q == '1) ? rc4_pkg::ST_IDLE : rc4_pkg::ST_K_RD;
			end
			rc4_pkg::ST_P_RDI:  state_d = rc4_pkg::ST_P_RDJ;
			rc4_pkg::ST_P_RDJ:  state_d = rc4_pkg::ST_P_WR_I;
			rc4_pkg::ST_P_WR_I: state_d = rc4_pkg::ST_P_WR_J;
			rc4_pkg::ST_P_WR_J: state_d = rc4_pkg::ST_P_RDK;
			rc4_pkg::ST_P_RDK:  state_d = rc4_pkg::ST_P_OUT;
			rc4_pkg::ST_P_OUT: begin
				if (out_free) begin
					state_d = rc4_pkg::ST_IDLE;
				end
			end
			default: state_d = rc4_pkg::ST_IDLE;
		endcase
	end

	// memory requests and adder operands
	always_comb begin
		sbox_req         = '0;
		key_req          = '0;
		add_a            = '0;
		add_b            = '0;
		add_c            = '0;
		key_req.wr_addr  = key_count_q[rc4_pkg::KEY_ADDR_W-1:0];
		key_req.wr_data  = din.value;
		key_req.rd_addr  = kidx_q[rc4_pkg::KEY_ADDR_W-1:0];
		case (state_q)
			rc4_pkg::ST_IDLE: begin
				add_a = i_q;
				add_b = rc4_pkg::byte_t'(1);
				if (accept && din.cmd == rc4_pkg::CMD_KEY) begin
					key_req.we   = store_ok;
					sbox_req.clr = din.key_last;
				end
			end
			rc4_pkg::ST_K_RD: begin
				sbox_req.rd_addr = n_q;
			end
			rc4_pkg::ST_K_ADD: begin
				add_a            = j_q;
				add_b            = sbox_rdata;
				add_c            = key_rdata;
				sbox_req.rd_addr = add_sum;
			end
			rc4_pkg::ST_K_WR_N: begin
				sbox_req.we      = 1'b1;
				sbox_req.wr_addr = n_q;
				sbox_req.wr_data = sbox_rdata;
			end
			rc4_pkg::ST_K_WR_J: begin
				sbox_req.we      = 1'b1;
				sbox_req.wr_addr = j_q;
				sbox_req.wr_data = si_q;
			end
			rc4_pkg::ST_P_RDI: begin
				sbox_req.rd_addr = i_q;
			end
			rc4_pkg::ST_P_RDJ: begin
				add_a            = j_q;
				add_b            = sbox_rdata;
				sbox_req.rd_addr = add_sum;
			end
			rc4_pkg::ST_P_WR_I: begin
				sbox_req.we      = 1'b1;
				sbox_req.wr_addr = i_q;
				sbox_req.wr_data = sbox_rdata;
			end
			rc4_pkg::ST_P_WR_J: begin
				sbox_req.we      = 1'b1;
				sbox_req.wr_addr = j_q;
				sbox_req.wr_data = si_q;
			end
			rc4_pkg::ST_P_RDK, rc4_pkg::ST_P_OUT: begin
				add_a            = si_q;
				add_b            = sj_q;
				sbox_req.rd_addr = add_sum;
			end
			default: begin
			end
		endcase
	end

	assign din.ready     = (state_q == rc4_pkg::ST_IDLE);
	assign dout.valid    = out_valid_q;
	assign dout.out_byte = out_q;

	// control and index registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rc4_pkg::ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			kidx_q      <= '0;
			key_count_q <= '0;
			len_q       <= rc4_pkg::CNT_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// raise the result when it loads, drop it once taken
			if (state_q == rc4_pkg::ST_P_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				rc4_pkg::ST_IDLE: begin
					if (accept) begin
						if (din.cmd == rc4_pkg::CMD_DATA) begin
							i_q <= add_sum;
						end else if (din.key_last) begin
							len_q       <= store_ok ? count_inc : key_count_q;
							key_count_q <= '0;
							n_q         <= '0;
							j_q         <= '0;
							kidx_q      <= '0;
						end else if (store_ok) begin
							key_count_q <= count_inc;
						end
					end
				end
				rc4_pkg::ST_K_ADD, rc4_pkg::ST_P_RDJ: begin
					j_q <= add_sum;
				end
				rc4_pkg::ST_K_WR_J: begin
					n_q    <= n_q + rc4_pkg::byte_t'(1);
					kidx_q <= (kidx_inc == len_q) ? '0 : kidx_inc[rc4_pkg::ADDR_W-1:0];
					if (n_q == '1) begin
						i_q <= '0;
						j_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= din.value;
		end
		if (state_q == rc4_pkg::ST_K_ADD || state_q == rc4_pkg::ST_P_RDJ) begin
			si_q <= sbox_rdata;
		end
		if (state_q == rc4_pkg::ST_P_WR_I) begin
			sj_q <= sbox_rdata;
		end
		if (state_q == rc4_pkg::ST_P_OUT && out_free) begin
			out_q <= val_q ^ sbox_rdata;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_wr_clr: assert property (@(posedge clk) disable iff (!arst_n)
		!(sbox_req.we && sbox_req.clr))
		else $error("sbox write and clear in the same cycle");
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rc4_pkg::ST_K_RD |->
			len_q != '0 && len_q <= rc4_pkg::CNT_W'(rc4_pkg::MAX_KEY_BYTES))
		else $error("key length out of range during schedule");
	a_kidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rc4_pkg::ST_K_RD |-> rc4_pkg::CNT_W'(kidx_q) < len_q)
		else $error("key index beyond key length");
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rc4_pkg::ST_P_OUT && state_d == rc4_pkg::ST_IDLE) |=> out_valid_q)
		else $error("data byte finished without a result");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= rc4_pkg::CNT_W'(rc4_pkg::MAX_KEY_BYTES))
		else $error("key count beyond store size");
`endif

endmodule
`default_nettype wire
